// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_PING   = 3'd1;
    localparam logic [2:0] KIND_CLOSE  = 3'd2;
    localparam logic [2:0] KIND_BADOP  = 3'd3;
    localparam logic [2:0] KIND_MASKED = 3'd4;
    localparam logic [2:0] KIND_EMPTY  = 3'd5;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;

    localparam logic [6:0] LEN_MAGIC_16 = 7'd126;
    localparam logic [6:0] LEN_MAGIC_64 = 7'd127;

    localparam logic [3:0] OP_CONT       = 4'd0;
    localparam logic [3:0] OP_TEXT       = 4'd1;
    localparam logic [3:0] OP_BIN        = 4'd2;
    localparam logic [3:0] OP_CTRL_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING       = 4'd9;
    localparam logic [3:0] OP_PONG       = 4'd10;

    typedef struct packed {
        logic       emit;
        logic [2:0] kind;
    } result_t;

endpackage

// ===== rtl/wsd_parser.sv =====
module wsd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_in,
    output wsd_pkg::result_t    res
);

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [3:0]  left_reg, left_next;
    logic [63:0] rem_reg, rem_next;
    logic [7:0]  close_high_reg, close_high_next;
    logic        halted_reg, halted_next;

    logic [6:0]  low7;
    logic [63:0] shifted;

    assign low7    = byte_in[6:0];
    assign shifted = {rem_reg[55:0], byte_in};

    always_comb
    begin
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        left_next       = left_reg;
        rem_next        = rem_reg;
        close_high_next = close_high_reg;
        halted_next     = halted_reg;
        res.emit        = 1'b0;
        res.kind        = wsd_pkg::KIND_DATA;
        if (!halted_reg)
        begin
            unique case (phase_reg)
                wsd_pkg::PH_HDR1:
                begin
                    if (byte_in[7])
                    begin
                        halted_next = 1'b1;
                        phase_next  = wsd_pkg::PH_HDR0;
                        res.emit    = 1'b1;
                        res.kind    = wsd_pkg::KIND_MASKED;
                    end
                    else if (low7 == wsd_pkg::LEN_MAGIC_16)
                    begin
                        rem_next   = '0;
                        left_next  = 4'd2;
                        phase_next = wsd_pkg::PH_EXT;
                    end
                    else if (low7 == wsd_pkg::LEN_MAGIC_64)
                    begin
                        rem_next   = '0;
                        left_next  = 4'd8;
                        phase_next = wsd_pkg::PH_EXT;
                    end
                    else
                    begin
                        rem_next  = {57'd0, low7};
                        left_next = 4'd0;
                        if (low7 == 7'd0)
                        begin
                            phase_next = wsd_pkg::PH_HDR0;
                            res.emit   = 1'b1;
                            res.kind   = wsd_pkg::KIND_EMPTY;
                        end
                        else
                        begin
                            phase_next = wsd_pkg::PH_PAY;
                        end
                    end
                end
                wsd_pkg::PH_EXT:
                begin
                    rem_next  = shifted;
                    left_next = left_reg - 4'd1;
                    if (left_reg == 4'd1)
                    begin
                        left_next = 4'd0;
                        if (shifted == 64'd0)
                        begin
                            phase_next = wsd_pkg::PH_HDR0;
                            res.emit   = 1'b1;
                            res.kind   = wsd_pkg::KIND_EMPTY;
                        end
                        else
                        begin
                            phase_next = wsd_pkg::PH_PAY;
                        end
                    end
                end
                wsd_pkg::PH_PAY:
                begin
                    if (opcode_reg <= wsd_pkg::OP_BIN)
                    begin
                        res.emit = 1'b1;
                        res.kind = wsd_pkg::KIND_DATA;
                    end
                    else if (opcode_reg == wsd_pkg::OP_PING)
                    begin
                        res.emit = 1'b1;
                        res.kind = wsd_pkg::KIND_PING;
                    end
                    else if (opcode_reg == wsd_pkg::OP_CTRL_CLOSE)
                    begin
                        if (left_reg == 4'd0)
                        begin
                            close_high_next = byte_in;
                            left_next       = 4'd1;
                        end
                        else if (left_reg == 4'd1)
                        begin
                            left_next = 4'd2;
                            res.emit  = 1'b1;
                            res.kind  = wsd_pkg::KIND_CLOSE;
                        end
                    end
                    rem_next = rem_reg - 64'd1;
                    if (rem_reg == 64'd1)
                    begin
                        left_next  = 4'd0;
                        phase_next = wsd_pkg::PH_HDR0;
                    end
                end
                default:
                begin
                    if (low7 == {3'd0, wsd_pkg::OP_CONT}       ||
                        low7 == {3'd0, wsd_pkg::OP_TEXT}       ||
                        low7 == {3'd0, wsd_pkg::OP_BIN}        ||
                        low7 == {3'd0, wsd_pkg::OP_CTRL_CLOSE} ||
                        low7 == {3'd0, wsd_pkg::OP_PING}       ||
                        low7 == {3'd0, wsd_pkg::OP_PONG})
                    begin
                        opcode_next = low7[3:0];
                        left_next   = 4'd0;
                        phase_next  = wsd_pkg::PH_HDR1;
                    end
                    else
                    begin
                        halted_next = 1'b1;
                        phase_next  = wsd_pkg::PH_HDR0;
                        res.emit    = 1'b1;
                        res.kind    = wsd_pkg::KIND_BADOP;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= wsd_pkg::PH_HDR0;
            opcode_reg     <= 4'd0;
            left_reg       <= 4'd0;
            rem_reg        <= 64'd0;
            close_high_reg <= 8'd0;
            halted_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            opcode_reg     <= opcode_next;
            left_reg       <= left_next;
            rem_reg        <= rem_next;
            close_high_reg <= close_high_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket frame deframer, receive side, unmasked frames only.
// Input channel: in_valid/in_ready/in_byte, one stream byte per beat,
// starting at the first header byte after the upgrade handshake.
// Output channel: out_valid/out_ready/kind, zero or one beat per input byte:
//   data byte, ping byte, close code ready (code bytes are the last two
//   input bytes), bad opcode, masked frame, empty frame.
// A result passes from the input register through the parser logic into
// the output register. Throughput: one byte per cycle sustained while
// the receiver takes results; the parser step, with its 64-bit
// remaining-length decrement and compare, is combinational.
// When the receiver stalls, the output register holds its beat; the input
// register still takes one more byte, then in_ready drops until the output
// frees up. That byte waits whether or not it gives a result.
// After a bad opcode or masked frame the block reports once and then drops
// every byte until reset. Reset (rst_n low) clears all parser state and
// the valid flags of both registers; in_ready is high right after reset.
module websocket_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind
);

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       kind_reg;
    logic             out_free;
    logic             advance;
    wsd_pkg::result_t res;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    wsd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (s1_byte_reg),
        .res     (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && res.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= in_byte;
        if (advance && res.emit)
            kind_reg <= res.kind;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;

endmodule

// ===== rtl/wsd_checker.sv =====
module wsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] kind
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind))
        else $error("output beat changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= wsd_pkg::KIND_EMPTY)
        else $error("kind out of range");

    // an error beat is the last result until reset
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready &&
        (kind == wsd_pkg::KIND_BADOP || kind == wsd_pkg::KIND_MASKED)
        |=> !out_valid)
        else $error("result after halt");

    // a fresh beat never appears without an earlier accepted input byte or an input stall
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        ##2 $rose(out_valid) |-> $past(in_valid && in_ready, 2) ||
        $past(!in_ready, 1) || $past(!in_ready, 2))
        else $error("result without input beat");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_byte))
        else $error("input beat changed while stalled");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind)
);
